FILE: hdl/rlbt_pkg.sv
// Shared types and constants for the row lane border tracker.
// No dependencies; every other file imports this package.
package rlbt_pkg;

    localparam int ROW_WIDTH = 64;
    localparam int ROW_COUNT = 64;
    localparam int PIX_W     = 64;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 6;
    localparam int VIS_W     = 7;
    localparam int CNT_W     = $clog2(ROW_WIDTH + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    // tracking window lower bound (exclusive)
    localparam int TRACK_FIRST_ROW = 4;

    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(ROW_WIDTH - 1);
    localparam logic [COL_W-1:0] START_COL = COL_W'(ROW_WIDTH / 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDE_ROAD_WIDTH   = 2'd0,
        CFG_SCAN_COMPENSATION = 2'd1,
        CFG_VISUAL_FIELD_ROWS = 2'd2,
        CFG_UNUSED            = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // scan sequencing from the controller
    typedef struct packed {
        logic load;
        logic step;
    } scan_ctrl_t;

    // pixel pair under the scan window: column c and column c-1
    typedef struct packed {
        logic cur;
        logic prev;
    } pix_pair_t;

endpackage

FILE: hdl/rlbt_pix_sreg.sv
// Pixel shift register: presents one column per cycle while stepped, lowest column first.
// Depends on rlbt_pkg.
module rlbt_pix_sreg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rlbt_pkg::scan_ctrl_t     ctrl,
    input  logic [rlbt_pkg::PIX_W-1:0] row_pixels,
    output rlbt_pkg::pix_pair_t      pair
);
    import rlbt_pkg::*;

    logic [ROW_WIDTH-1:0] sreg_reg, sreg_next;
    logic                 prev_reg, prev_next;

    always_comb
    begin
        sreg_next = sreg_reg;
        prev_next = prev_reg;
        if (ctrl.load)
        begin
            sreg_next = row_pixels[ROW_WIDTH-1:0];
            prev_next = 1'b0;          // column -1 reads as clear
        end
        else if (ctrl.step)
        begin
            sreg_next = {1'b0, sreg_reg[ROW_WIDTH-1:1]};  // beyond row reads clear
            prev_next = sreg_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sreg_reg <= sreg_next;
    end

    assign pair.cur  = sreg_reg[0];
    assign pair.prev = prev_reg;

endmodule

FILE: hdl/rlbt_edge_scan.sv
// Edge recorder: watches the serial pixel pair and keeps the left and right borders.
// Depends on rlbt_pkg.
module rlbt_edge_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rlbt_pkg::scan_ctrl_t      ctrl,
    input  rlbt_pkg::pix_pair_t       pair,
    input  logic [rlbt_pkg::CNT_W-1:0] col_cnt,
    input  logic [rlbt_pkg::COL_W-1:0] left_start,
    input  logic [rlbt_pkg::COL_W-1:0] right_start,
    output logic [rlbt_pkg::COL_W-1:0] left_col,
    output logic [rlbt_pkg::COL_W-1:0] right_col,
    output logic                      left_hit,
    output logic                      right_hit
);
    import rlbt_pkg::*;

    logic [COL_W-1:0] left_reg, left_next;
    logic [COL_W-1:0] right_reg, right_next;
    logic             lfound_reg, lfound_next;
    logic             rfound_reg, rfound_next;
    logic             left_edge, right_edge;
    logic [CNT_W-1:0] col_prev;

    assign col_prev = col_cnt - CNT_W'(1);

    // set-then-clear at (c-1, c); the highest one not above the start wins
    assign left_edge = (col_cnt != '0) && pair.prev && !pair.cur &&
                       (col_cnt <= CNT_W'(left_start) + CNT_W'(1));
    // clear-then-set at (c-1, c); the first one from the start wins
    assign right_edge = !rfound_reg && !pair.prev && pair.cur &&
                        (col_cnt >= CNT_W'(right_start)) &&
                        (col_cnt < CNT_W'(ROW_WIDTH));

    always_comb
    begin
        left_next   = left_reg;
        right_next  = right_reg;
        lfound_next = lfound_reg;
        rfound_next = rfound_reg;
        if (ctrl.load)
        begin
            left_next   = '0;
            right_next  = LAST_COL;
            lfound_next = 1'b0;
            rfound_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            if (left_edge)
            begin
                left_next   = col_prev[COL_W-1:0];
                lfound_next = 1'b1;
            end
            if (right_edge)
            begin
                right_next  = col_cnt[COL_W-1:0];
                rfound_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfound_reg <= 1'b0;
            rfound_reg <= 1'b0;
        end
        else
        begin
            lfound_reg <= lfound_next;
            rfound_reg <= rfound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    assign left_col  = left_reg;
    assign right_col = right_reg;
    assign left_hit  = lfound_reg;
    assign right_hit = rfound_reg;

endmodule

FILE: hdl/row_lane_border_tracker.sv
// Top level of the row lane border tracker: control, search starts, trackers, result register.
// Depends on rlbt_pkg, rlbt_pix_sreg and rlbt_edge_scan.

// One binary row is taken per item and scanned one column per clock, lowest column first,
// through a shift register; both border searches run on that single pass. After every column
// and the past-the-edge column are scanned, the middle is formed and the trackers are updated.
// Only one row is in flight at a time: in_stall stays high from acceptance until the result
// is moved into the output register, which holds it while the next row is scanned, so a new
// row is not taken before the previous result has been moved into the output register.
// Configuration writes are always ready and should only be issued while the block is idle.
module row_lane_border_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rlbt_pkg::PIX_W-1:0]     row_pixels,
    input  logic [rlbt_pkg::ROW_W-1:0]     row_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rlbt_pkg::COL_W-1:0]     left_border,
    output logic [rlbt_pkg::COL_W-1:0]     right_border,
    output logic [rlbt_pkg::COL_W-1:0]     middle_column,
    output logic                           left_found,
    output logic                           right_found,
    output logic [rlbt_pkg::ROW_W-1:0]     least_middle_row,
    output logic [rlbt_pkg::ROW_W-1:0]     greatest_middle_row,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rlbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rlbt_pkg::CFG_DAT_W-1:0] cfg_data
);
    import rlbt_pkg::*;

    state_t           state_reg, state_next;
    scan_ctrl_t       ctrl;
    pix_pair_t        pair;
    logic             accept, commit;
    logic             scan_step;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0] lstart_reg, lstart_next;
    logic [COL_W-1:0] rstart_reg, rstart_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [COL_W-1:0] wide_reg, comp_reg;
    logic [VIS_W-1:0] vis_reg;

    logic [COL_W-1:0] prev_left_reg, prev_right_reg, prev_mid_reg;
    logic [ROW_W-1:0] least_row_reg, greatest_row_reg;
    logic [COL_W-1:0] least_val_reg, greatest_val_reg;

    logic [COL_W-1:0] scan_left, scan_right;
    logic             scan_lhit, scan_rhit;
    logic [COL_W:0]   mid_sum;
    logic [COL_W-1:0] mid;
    logic             track_row;
    logic signed [COL_W+1:0] spread;

    logic             ovalid_reg;
    logic [COL_W-1:0] o_left_reg, o_right_reg, o_mid_reg;
    logic             o_lf_reg, o_rf_reg;

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(ROW_WIDTH))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        scan_step = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
            end
            ST_DONE:
            begin
                commit = !ovalid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept    = in_valid && !in_stall;
    // packed as {load, step}
    assign ctrl      = {accept, scan_step};
    assign cfg_ready = 1'b1;

    // ---------------- search starts ----------------
    assign spread = $signed({2'b00, prev_right_reg}) - $signed({2'b00, prev_left_reg});

    always_comb
    begin
        cnt_next    = cnt_reg;
        lstart_next = lstart_reg;
        rstart_next = rstart_reg;
        row_next    = row_reg;
        if (accept)
        begin
            cnt_next = '0;
            row_next = row_index;
            if (row_index == '0)
            begin
                lstart_next = START_COL;
                rstart_next = START_COL;
            end
            else
            begin
                lstart_next = prev_mid_reg;
                rstart_next = prev_mid_reg;
                if (spread > $signed({2'b00, wide_reg}))
                begin
                    // negative start clamps to column 0
                    if (comp_reg > prev_mid_reg)
                        rstart_next = '0;
                    else
                        rstart_next = prev_mid_reg - comp_reg;
                end
            end
        end
        else if (ctrl.step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // ---------------- datapath ----------------
    rlbt_pix_sreg u_sreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .row_pixels (row_pixels),
        .pair       (pair)
    );

    rlbt_edge_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .pair        (pair),
        .col_cnt     (cnt_reg),
        .left_start  (lstart_reg),
        .right_start (rstart_reg),
        .left_col    (scan_left),
        .right_col   (scan_right),
        .left_hit    (scan_lhit),
        .right_hit   (scan_rhit)
    );

    assign mid_sum   = {1'b0, scan_left} + {1'b0, scan_right};
    assign mid       = mid_sum[COL_W:1];
    assign track_row = (int'(row_reg) > TRACK_FIRST_ROW) &&
                       ({1'b0, row_reg} < vis_reg) &&
                       (int'(row_reg) < ROW_COUNT);

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            wide_reg         <= COL_W'(32);
            comp_reg         <= '0;
            vis_reg          <= VIS_W'(64);
            prev_left_reg    <= '0;
            prev_right_reg   <= '0;
            prev_mid_reg     <= '0;
            least_row_reg    <= '0;
            greatest_row_reg <= '0;
            least_val_reg    <= '0;
            greatest_val_reg <= '0;
            ovalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_WIDE_ROAD_WIDTH:   wide_reg <= cfg_data[COL_W-1:0];
                    CFG_SCAN_COMPENSATION: comp_reg <= cfg_data[COL_W-1:0];
                    CFG_VISUAL_FIELD_ROWS: vis_reg  <= cfg_data[VIS_W-1:0];
                    default:               vis_reg  <= vis_reg;
                endcase
            end

            if (commit)
            begin
                prev_left_reg  <= scan_left;
                prev_right_reg <= scan_right;
                prev_mid_reg   <= mid;
                if (row_reg == '0)
                begin
                    // new frame: both trackers restart at row 0
                    least_row_reg    <= '0;
                    greatest_row_reg <= '0;
                    least_val_reg    <= mid;
                    greatest_val_reg <= mid;
                end
                else if (track_row)
                begin
                    if (mid < least_val_reg)
                    begin
                        least_row_reg <= row_reg;
                        least_val_reg <= mid;
                    end
                    else if (mid > greatest_val_reg)
                    begin
                        greatest_row_reg <= row_reg;
                        greatest_val_reg <= mid;
                    end
                end
            end

            if (commit)
                ovalid_reg <= 1'b1;
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        lstart_reg <= lstart_next;
        rstart_reg <= rstart_next;
        row_reg    <= row_next;
        if (commit)
        begin
            o_left_reg  <= scan_left;
            o_right_reg <= scan_right;
            o_mid_reg   <= mid;
            o_lf_reg    <= scan_lhit;
            o_rf_reg    <= scan_rhit;
        end
    end

    assign out_valid           = ovalid_reg;
    assign left_border         = o_left_reg;
    assign right_border        = o_right_reg;
    assign middle_column       = o_mid_reg;
    assign left_found          = o_lf_reg;
    assign right_found         = o_rf_reg;
    // trackers only move at commit, so they match the registered item
    assign least_middle_row    = least_row_reg;
    assign greatest_middle_row = greatest_row_reg;

endmodule

FILE: hdl/rlbt_checker.sv
// Port-level checks for the row lane border tracker, bound to the top level.
// Depends on rlbt_pkg and row_lane_border_tracker.
module rlbt_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [rlbt_pkg::COL_W-1:0]     left_border,
    input  logic [rlbt_pkg::COL_W-1:0]     right_border,
    input  logic                           left_found,
    input  logic                           right_found
);
    import rlbt_pkg::*;

    // a result held back is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // one row at a time: the scan blocks further input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a row is being scanned");

    a_left_default: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !left_found |-> left_border == '0)
        else $error("left border not zero when not found");

    a_right_default: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !right_found |-> right_border == LAST_COL)
        else $error("right border not last column when not found");

endmodule

bind row_lane_border_tracker rlbt_checker u_rlbt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_border  (left_border),
    .right_border (right_border),
    .left_found   (left_found),
    .right_found  (right_found)
);
